### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/spq_pkg.sv
// Types, widths and codes of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int PRIO_W    = 16;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 7;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } cell_cmd_t;

endpackage

### sv/spq_if.sv
// Request and response channel interfaces of the priority queue.
interface spq_req_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [PRIO_W-1:0]        item_priority;
    logic signed [DATA_W-1:0] item_data;

    modport source (output valid, func, item_priority, item_data, input ready);
    modport sink   (input valid, func, item_priority, item_data, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_level;

    modport source (output valid, out_data, out_priority, status, fill_level, input ready);
    modport sink   (input valid, out_data, out_priority, status, fill_level, output ready);
endinterface

### sv/sorted_priority_queue_top.sv
// A word accepted at one edge shows its result word at the output from the next cycle.
// One word is taken per cycle while the response side takes results; every cell updates at
// once (parallel compare across the chain, then one shift).
// Reset (rst_n, async, active low) empties the queue and drops any pending result word.
// The entry storage is not cleared; the fill count alone marks which cells hold entries.
`include "assert_macros.svh"

module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic    clk,
    input logic    rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    // Count has to hold DEPTH itself.
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // ------------------------------------------------------------------
    // Handshake: a new word may enter when the result register is empty
    // or being drained in this same cycle.
    // ------------------------------------------------------------------
    logic req_acc;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Fill count and command decode
    // ------------------------------------------------------------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          empty;
    logic          rejected;
    cell_cmd_t     cmd;

    assign full  = count_reg == DEPTH_C;
    assign empty = count_reg == '0;
    // Insert that finds no free cell; the word is dropped.
    assign rejected = req_acc && (req.func == FUNC_INSERT) && full;

    always_comb
    begin
        cmd.ins       = req_acc && (req.func == FUNC_INSERT) && !full;
        cmd.rem       = req_acc && (req.func == FUNC_REMOVE) && !empty;
        cmd.item.prio = req.item_priority;
        cmd.item.data = req.item_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + ONE_C;
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - ONE_C;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell 0 holds the smallest priority (head of queue).
    // Insert shifts the tail up past the new entry; remove shifts down.
    // ------------------------------------------------------------------
    entry_t cell_entry [DEPTH];
    logic   cell_gt    [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // ------------------------------------------------------------------
    // Result word register
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] out_data_reg;
    logic signed [DATA_W-1:0] out_data_next;
    logic [PRIO_W-1:0]        out_prio_reg;
    logic [PRIO_W-1:0]        out_prio_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic [CW+FILL_W-1:0]     count_ext;

    // Fill level is the count masked to the output width.
    assign count_ext = {{FILL_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_acc)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_prio_next = '0;
        status_next   = STATUS_DONE;
        fill_next     = count_ext[FILL_W-1:0];
        if (req.func == FUNC_REMOVE)
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                out_data_next = cell_entry[0].data;
                out_prio_next = cell_entry[0].prio;
            end
        end
        else if (full)
        begin
            status_next = STATUS_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            out_data_reg <= out_data_next;
            out_prio_reg <= out_prio_next;
            status_reg   <= status_next;
            fill_reg     <= fill_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_data     = out_data_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.status       = status_reg;
    assign rsp.fill_level   = fill_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, rsp_valid_reg && !rsp.ready, $stable(count_reg))
    `ASSERT_NEXT(a_full_reject, clk, rst_n, rejected, status_reg == STATUS_FULL && $stable(count_reg))
    `ASSERT_NEXT(a_remove_count, clk, rst_n, cmd.rem, count_reg == $past(count_reg) - ONE_C)

endmodule

### sv/spq_cell.sv
// One slot of the sorted shift register: holds an entry, trades with its neighbors.
module spq_cell import spq_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic          clk,
    input  cell_cmd_t     cmd,
    input  logic [CW-1:0] count,
    input  entry_t        left_entry,
    input  logic          left_gt,
    input  entry_t        right_entry,
    output entry_t        entry,
    output logic          gt
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   at_end;

    assign occupied = IDX_C < count;
    assign at_end   = IDX_C == count;
    // Holds an entry that must move up past the new one.
    assign gt       = occupied && (entry_reg.prio > cmd.item.prio);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.rem)
        begin
            entry_next = right_entry;
        end
        else if (cmd.ins)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || at_end)
            begin
                entry_next = cmd.item;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
